FILE: rtl/lpbl_pkg.sv
// shared types and constants for the largest-prime search block
`timescale 1ns / 1ps
package lpbl_pkg;

   localparam int DEF_VALUE_WIDTH = 16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TEST,
      ST_DIV,
      ST_OUT
   } lpbl_state_type;

   typedef struct packed {
      logic done;
      logic rem_zero;
   } lpbl_div_status_type;

endpackage

FILE: rtl/largest_prime_below_limit.sv
// largest prime strictly below a limit: sequencer around a shared remainder unit
//
// req channel: one word per search, tdata holds the limit (unsigned, exclusive).
// rsp channel: one word per search; tuser is the found flag, tdata the prime
// (zero when no prime lies below the limit, i.e. a limit of 2 or less).
// The block takes one search at a time: req_tready is high only while idle.
// Candidates are tested from limit-1 downwards with divisors 2, 3, ... while
// divisor squared stays within the candidate; the square is kept by adding
// 2d+1 per step. Each divisor is tried in the bit-serial remainder unit, so
// a search runs longer the more divisors are tried over all candidates.
// Limits of 2 or less answer in the cycle after acceptance.
// The result is held in registers with rsp_tvalid high until rsp_tready;
// the next search is taken once it has gone.
// Reset returns the sequencer to idle and drops any search in progress.
`timescale 1ns / 1ps
module largest_prime_below_limit #(
   parameter int VALUE_WIDTH = lpbl_pkg::DEF_VALUE_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      req_tdata,   // limit
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((VALUE_WIDTH+7)/8)*8-1:0]      rsp_tdata,   // prime_value
   output logic                                  rsp_tuser    // found
);
   import lpbl_pkg::*;

   localparam int DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

   lpbl_state_type         state_ff, state_in;
   logic [VALUE_WIDTH-1:0] cand_ff, cand_in;
   logic [VALUE_WIDTH-1:0] div_ff, div_in;
   logic [VALUE_WIDTH:0]   sq_ff, sq_in;
   logic                   found_ff, found_in;
   logic [VALUE_WIDTH-1:0] prime_ff, prime_in;
   logic [VALUE_WIDTH-1:0] limit;
   logic                   sq_over;
   logic                   div_start;
   lpbl_div_status_type    div_status;

   assign limit   = req_tdata[VALUE_WIDTH-1:0];
   assign sq_over = (sq_ff > {1'b0, cand_ff});

   lpbl_rem #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cand_ff),
      .divisor  (div_ff),
      .status   (div_status)
   );

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      cand_in  = cand_ff;
      div_in   = div_ff;
      sq_in    = sq_ff;
      found_in = found_ff;
      prime_in = prime_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cand_in = limit - 1'b1;
               div_in  = VALUE_WIDTH'(2);
               sq_in   = (VALUE_WIDTH+1)'(4);
               if (limit <= VALUE_WIDTH'(2)) begin
                  found_in = 1'b0;
                  prime_in = '0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_TEST;
               end
            end
         end
         ST_TEST: begin
            // no divisor up to the square root: candidate is prime
            if (sq_over) begin
               found_in = 1'b1;
               prime_in = cand_ff;
               state_in = ST_OUT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               if (div_status.rem_zero) begin
                  cand_in = cand_ff - 1'b1;
                  div_in  = VALUE_WIDTH'(2);
                  sq_in   = (VALUE_WIDTH+1)'(4);
               end else begin
                  div_in = div_ff + 1'b1;
                  sq_in  = sq_ff + {div_ff, 1'b1};
               end
               state_in = ST_TEST;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_TEST: div_start  = !sq_over;
         ST_OUT:  rsp_tvalid = 1'b1;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cand_ff  <= cand_in;
      div_ff   <= div_in;
      sq_ff    <= sq_in;
      found_ff <= found_in;
      prime_ff <= prime_in;
   end

   assign rsp_tdata = DATA_W'(prime_ff);
   assign rsp_tuser = found_ff;

   a_no_take_while_holding : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while a result is pending");

   a_not_found_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("prime field not zero without a find");

   a_found_at_least_two : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[VALUE_WIDTH-1:0] >= VALUE_WIDTH'(2)))
      else $error("reported prime below two");

   a_div_done_only_in_div : assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("remainder finished outside the divide step");

endmodule

FILE: rtl/lpbl_rem.sv
// bit-serial restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps
module lpbl_rem #(
   parameter int VALUE_WIDTH = lpbl_pkg::DEF_VALUE_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [VALUE_WIDTH-1:0]           dividend,
   input  logic [VALUE_WIDTH-1:0]           divisor,
   output lpbl_pkg::lpbl_div_status_type    status
);
   import lpbl_pkg::*;

   localparam int CNT_W = $clog2(VALUE_WIDTH);

   logic [VALUE_WIDTH:0]   rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] dvd_ff, dvd_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [VALUE_WIDTH:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[VALUE_WIDTH-1:0], dvd_ff[VALUE_WIDTH-1]};
      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         cnt_in  = CNT_W'(VALUE_WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit and subtract when it fits
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
         end else begin
            rem_in = trial;
         end
         dvd_in = {dvd_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
   end

   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule

FILE: test/lpbl_checker.sv
// checker for the largest-prime search block: predicts each result and compares it
`timescale 1ns / 1ps
module lpbl_checker #(
   parameter int VALUE_WIDTH = lpbl_pkg::DEF_VALUE_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      req_tdata,   // limit
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      rsp_tdata,   // prime_value
   input  logic                                  rsp_tuser,   // found
   output int                                    error_count,
   output int                                    pending_count,
   output int                                    checked_count
);

   localparam int DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

   typedef struct packed {
      logic                   found;
      logic [VALUE_WIDTH-1:0] prime_value;
   } prime_result_type;

   prime_result_type expected_primes[$];

   // trial division from limit-1 downwards, divisors while d*d stays within the candidate
   function automatic prime_result_type largest_prime_below(input logic [VALUE_WIDTH-1:0] limit);
      prime_result_type res;
      longint unsigned cand;
      longint unsigned d;
      bit divisible;
      res.found = 1'b0;
      res.prime_value = '0;
      if (limit > 2) begin
         cand = limit - 1;
         while (cand >= 2 && !res.found) begin
            divisible = 1'b0;
            for (d = 2; d * d <= cand && !divisible; d++) begin
               if (cand % d == 0) divisible = 1'b1;
            end
            if (!divisible) begin
               res.found = 1'b1;
               res.prime_value = cand[VALUE_WIDTH-1:0];
            end
            cand--;
         end
      end
      return res;
   endfunction

   initial begin
      error_count = 0;
      pending_count = 0;
      checked_count = 0;
   end

   always @(posedge clock) begin
      prime_result_type want;
      logic [DATA_W-1:0] want_data;
      int errs;
      errs = 0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_primes.push_back(largest_prime_below(req_tdata[VALUE_WIDTH-1:0]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_primes.size() == 0) begin
               $error("result word with no search outstanding: found %0d prime_value %0d",
                      rsp_tuser, rsp_tdata);
               errs++;
            end else begin
               want = expected_primes.pop_front();
               want_data = '0;
               want_data[VALUE_WIDTH-1:0] = want.prime_value;
               if (rsp_tuser !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_tuser);
                  errs++;
               end
               if (rsp_tdata !== want_data) begin
                  $error("prime_value: expected %0d, actual %0d", want_data, rsp_tdata);
                  errs++;
               end
               checked_count <= checked_count + 1;
            end
         end
         error_count <= error_count + errs;
         pending_count <= expected_primes.size();
      end
   end

endmodule

FILE: test/tb_top.sv
// top of the largest-prime search testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_top;

   localparam int VALUE_WIDTH    = lpbl_pkg::DEF_VALUE_WIDTH;
   localparam int DATA_W         = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int RANDOM_ITEMS   = 115;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int HOLD_CYCLES    = 300;
   localparam int HOLD_AT_RESULT = 30;
   localparam int DRAIN_CYCLES   = 20;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic              rsp_tuser;

   int error_count;
   int pending_count;
   int checked_count;
   int idle_cycles;
   int directed_sent;
   int random_sent;
   int large_sent;
   int results_taken;
   bit steady;

   int unsigned directed_limits[$] = '{
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 25, 49, 121, 256,
      32768, 'h5555, 'hAAAA, 65521, 65522, 65534, 65535
   };

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   largest_prime_below_limit #(.VALUE_WIDTH(VALUE_WIDTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   lpbl_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // offer one limit word after a random gap (none while steady) and hold it until taken
   task automatic send_limit(input int unsigned limit);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'(limit);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // result side: random stalls (none while steady), one long hold-off so the block backs up its input
   initial begin
      int hold;
      results_taken = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = (results_taken == HOLD_AT_RESULT) ? HOLD_CYCLES :
                (steady ? 0 : $urandom_range(0, 8));
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         results_taken++;
         @(negedge clock);
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int unsigned limit;
      int unsigned pick;
      directed_sent = 0;
      random_sent = 0;
      large_sent = 0;
      steady = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_limits[i]) begin
         send_limit(directed_limits[i]);
         directed_sent++;
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // let everything drain once, then carry on
         if (n == 70) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (pending_count != 0) @(negedge clock);
         end
         steady = (n >= 90 && n < 110);
         pick = $urandom_range(0, 99);
         // mostly small limits keep the run short, a few reach the full width
         if (pick < 60)
            limit = $urandom_range(0, 255);
         else if (pick < 80)
            limit = $urandom_range(0, 4095);
         else if (pick < 93) begin
            limit = $urandom_range(0, (1 << VALUE_WIDTH) - 1);
            large_sent++;
         end else
            limit = directed_limits[$urandom_range(0, directed_limits.size() - 1)];
         send_limit(limit);
         random_sent++;
      end
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("sent %0d directed and %0d random limits (%0d across the full width)",
               directed_sent, random_sent, large_sent);
      $display("checked %0d results, with a long output stall and a full drain mid-run",
               checked_count);
      if (error_count == 0 && pending_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: sim.f
rtl/lpbl_pkg.sv
rtl/lpbl_rem.sv
rtl/largest_prime_below_limit.sv
test/lpbl_checker.sv
test/tb_top.sv
